[hw/rtl/assert_macros.svh]
// Assertion macros used by the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond) \
    `ASSERT_CLK(lbl, clk_sig, rst_sig, !(cond))
`else
`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond)
`endif

`endif

[hw/rtl/sjf_pkg.sv]
// Types and constants of the shortest-job-first scheduler
package sjf_pkg;

    localparam int NUM_JOBS      = 8;
    localparam int TIME_BITS     = 16;
    localparam int ID_BITS       = 3;
    localparam int BURST_BITS    = 10;
    localparam int OUT_TIME_BITS = 16;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef logic [TIME_BITS-1:0]     time_t;
    typedef logic [OUT_TIME_BITS-1:0] out_time_t;
    typedef logic [ID_BITS-1:0]       id_t;
    typedef logic [BURST_BITS-1:0]    burst_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_TICK
    } cell_op_t;

    typedef struct packed {
        id_t    id;
        burst_t burst;
        burst_t served;
        time_t  arrival;
    } job_data_t;

    typedef struct packed {
        logic      valid;
        job_data_t data;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctrl_t;

endpackage

[hw/rtl/sjf_cmd_if.sv]
// Input channel: arrival and tick items
interface sjf_cmd_if;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    sjf_pkg::id_t         job_id;
    sjf_pkg::burst_t      burst_length;

    modport source (output valid, operation, job_id, burst_length, input ready);
    modport sink   (input valid, operation, job_id, burst_length, output ready);
endinterface

[hw/rtl/sjf_result_if.sv]
// Output channel: one result item per input item
interface sjf_result_if;
    logic                 valid;
    logic                 ready;
    logic                 segment_valid;
    sjf_pkg::id_t         segment_job;
    sjf_pkg::out_time_t   segment_begin;
    sjf_pkg::out_time_t   segment_end;
    logic                 job_done;
    sjf_pkg::out_time_t   turnaround;
    sjf_pkg::out_time_t   waiting;
    logic                 running_valid;
    sjf_pkg::id_t         running_job;
    logic                 arrival_rejected;

    modport source (output valid, segment_valid, segment_job, segment_begin, segment_end,
                    job_done, turnaround, waiting, running_valid, running_job,
                    arrival_rejected, input ready);
    modport sink   (input valid, segment_valid, segment_job, segment_begin, segment_end,
                    job_done, turnaround, waiting, running_valid, running_job,
                    arrival_rejected, output ready);
endinterface

[hw/rtl/sjf_cell.sv]
// One slot of the sorted job queue
module sjf_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sjf_pkg::cell_ctrl_t ctrl,
    input  sjf_pkg::entry_t     left_entry,
    input  sjf_pkg::entry_t     right_entry,
    input  logic                left_lt,
    output sjf_pkg::entry_t     entry,
    output logic                lt
);

    logic               valid_reg;
    logic               valid_next;
    sjf_pkg::job_data_t data_reg;
    sjf_pkg::job_data_t data_next;

    // this slot holds a strictly shorter job than the one being inserted
    assign lt = valid_reg && (data_reg.burst < ctrl.new_entry.data.burst);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (ctrl.op)
            sjf_pkg::CELL_INSERT:
            begin
                if (!lt)
                begin
                    if (left_lt)
                    begin
                        valid_next = ctrl.new_entry.valid;
                        data_next  = ctrl.new_entry.data;
                    end
                    else
                    begin
                        valid_next = left_entry.valid;
                        data_next  = left_entry.data;
                    end
                end
            end
            sjf_pkg::CELL_POP:
            begin
                valid_next = right_entry.valid;
                data_next  = right_entry.data;
            end
            sjf_pkg::CELL_TICK:
            begin
                data_next.served = data_reg.served + 1'b1;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;

endmodule

[hw/rtl/preemptive_sjf_scheduler.sv]
// Preemptive shortest-job-first scheduler: top level with control and result register
// Each item is registered on acceptance; once the output register is free, the row of
// queue cells inserts the job in burst order, pops the finished head, or advances the
// head's service count, while the result item is written to the output register. The
// next item is accepted in the cycle after that, even while the result still waits; an
// item waits in its input register only while an earlier result has not been taken.
// Queue slots are cleared at reset; there is no clearing pass.
`include "assert_macros.svh"

module preemptive_sjf_scheduler (
    input  logic         clk,
    input  logic         rst_n,
    sjf_cmd_if.sink      cmd,
    sjf_result_if.source result
);

    typedef struct packed {
        logic               segment_valid;
        sjf_pkg::id_t       segment_job;
        sjf_pkg::out_time_t segment_begin;
        sjf_pkg::out_time_t segment_end;
        logic               job_done;
        sjf_pkg::out_time_t turnaround;
        sjf_pkg::out_time_t waiting;
        logic               running_valid;
        sjf_pkg::id_t       running_job;
        logic               arrival_rejected;
    } result_t;

    localparam logic [sjf_pkg::NUM_JOBS-1:0] ONE_VEC = {{(sjf_pkg::NUM_JOBS-1){1'b0}}, 1'b1};

    logic            busy_reg;
    logic            op_reg;
    sjf_pkg::id_t    id_reg;
    sjf_pkg::burst_t burst_reg;

    logic            out_valid_reg;
    result_t         result_reg;
    result_t         result_next;

    sjf_pkg::time_t  time_now_reg;
    sjf_pkg::time_t  time_now_next;
    logic            head_started_reg;
    logic            head_started_next;
    sjf_pkg::time_t  head_start_time_reg;
    sjf_pkg::time_t  head_start_time_next;

    sjf_pkg::entry_t     cell_entry [sjf_pkg::NUM_JOBS];
    logic                cell_lt    [sjf_pkg::NUM_JOBS];
    sjf_pkg::cell_ctrl_t cell_ctrl  [sjf_pkg::NUM_JOBS];
    logic [sjf_pkg::NUM_JOBS-1:0] valid_vec;

    logic            execute;
    logic            active;
    logic            reject;
    logic            preempt;
    logic            done;
    sjf_pkg::burst_t served_inc;
    sjf_pkg::time_t  time_inc;
    sjf_pkg::time_t  turn;
    sjf_pkg::time_t  wait_time;
    sjf_pkg::time_t  begin_time;
    sjf_pkg::cell_op_t head_op;
    sjf_pkg::cell_op_t rest_op;
    sjf_pkg::entry_t   new_entry;

    genvar g;
    generate
        for (g = 0; g < sjf_pkg::NUM_JOBS; g++)
        begin : g_cell
            sjf_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl[g]),
                .left_entry  ((g == 0) ? sjf_pkg::entry_t'('0) : cell_entry[(g == 0) ? 0 : g - 1]),
                .right_entry ((g == sjf_pkg::NUM_JOBS - 1) ? sjf_pkg::entry_t'('0)
                              : cell_entry[(g == sjf_pkg::NUM_JOBS - 1) ? g : g + 1]),
                .left_lt     ((g == 0) ? 1'b1 : cell_lt[(g == 0) ? 0 : g - 1]),
                .entry       (cell_entry[g]),
                .lt          (cell_lt[g])
            );
            assign valid_vec[g] = cell_entry[g].valid;
        end
    endgenerate

    assign execute   = busy_reg && (!out_valid_reg || result.ready);
    assign cmd.ready = !busy_reg;

    always_comb
    begin
        active = 1'b0;
        for (int p = 0; p < sjf_pkg::NUM_JOBS; p++)
        begin
            if (cell_entry[p].valid && (cell_entry[p].data.id == id_reg))
            begin
                active = 1'b1;
            end
        end
    end

    assign reject = (int'(id_reg) >= sjf_pkg::NUM_JOBS) || active || (burst_reg == '0)
                    || cell_entry[sjf_pkg::NUM_JOBS-1].valid;
    assign preempt    = cell_entry[0].valid && !cell_lt[0];
    assign served_inc = cell_entry[0].data.served + 1'b1;
    assign done       = served_inc >= cell_entry[0].data.burst;
    assign time_inc   = time_now_reg + 1'b1;
    assign turn       = time_inc - cell_entry[0].data.arrival;
    assign wait_time  = turn - sjf_pkg::time_t'(cell_entry[0].data.burst);
    assign begin_time = head_started_reg ? head_start_time_reg : time_now_reg;

    always_comb
    begin
        new_entry.valid        = 1'b1;
        new_entry.data.id      = id_reg;
        new_entry.data.burst   = burst_reg;
        new_entry.data.served  = '0;
        new_entry.data.arrival = time_now_reg;

        head_op              = sjf_pkg::CELL_HOLD;
        rest_op              = sjf_pkg::CELL_HOLD;
        result_next          = '0;
        time_now_next        = time_now_reg;
        head_started_next    = head_started_reg;
        head_start_time_next = head_start_time_reg;

        if (op_reg == sjf_pkg::OP_ARRIVAL)
        begin
            if (reject)
            begin
                result_next.arrival_rejected = 1'b1;
                result_next.running_valid    = cell_entry[0].valid;
                result_next.running_job      = cell_entry[0].valid ? cell_entry[0].data.id : '0;
            end
            else
            begin
                head_op = sjf_pkg::CELL_INSERT;
                rest_op = sjf_pkg::CELL_INSERT;
                if (preempt)
                begin
                    head_started_next = 1'b0;
                    if (head_started_reg)
                    begin
                        result_next.segment_valid = 1'b1;
                        result_next.segment_job   = cell_entry[0].data.id;
                        result_next.segment_begin = sjf_pkg::out_time_t'(head_start_time_reg);
                        result_next.segment_end   = sjf_pkg::out_time_t'(time_now_reg);
                    end
                end
                result_next.running_valid = 1'b1;
                result_next.running_job   = (preempt || !cell_entry[0].valid) ? id_reg
                                            : cell_entry[0].data.id;
            end
        end
        else
        begin
            time_now_next = time_inc;
            if (cell_entry[0].valid)
            begin
                if (!head_started_reg)
                begin
                    head_started_next    = 1'b1;
                    head_start_time_next = time_now_reg;
                end
                if (done)
                begin
                    head_op                   = sjf_pkg::CELL_POP;
                    rest_op                   = sjf_pkg::CELL_POP;
                    head_started_next         = 1'b0;
                    result_next.segment_valid = 1'b1;
                    result_next.segment_job   = cell_entry[0].data.id;
                    result_next.segment_begin = sjf_pkg::out_time_t'(begin_time);
                    result_next.segment_end   = sjf_pkg::out_time_t'(time_inc);
                    result_next.job_done      = 1'b1;
                    result_next.turnaround    = sjf_pkg::out_time_t'(turn);
                    result_next.waiting       = sjf_pkg::out_time_t'(wait_time);
                    result_next.running_valid = cell_entry[1].valid;
                    result_next.running_job   = cell_entry[1].valid ? cell_entry[1].data.id : '0;
                end
                else
                begin
                    head_op                   = sjf_pkg::CELL_TICK;
                    result_next.running_valid = 1'b1;
                    result_next.running_job   = cell_entry[0].data.id;
                end
            end
        end

        for (int p = 0; p < sjf_pkg::NUM_JOBS; p++)
        begin
            cell_ctrl[p].new_entry = new_entry;
            if (!execute)
            begin
                cell_ctrl[p].op = sjf_pkg::CELL_HOLD;
            end
            else if (p == 0)
            begin
                cell_ctrl[p].op = head_op;
            end
            else
            begin
                cell_ctrl[p].op = rest_op;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg            <= 1'b0;
            out_valid_reg       <= 1'b0;
            time_now_reg        <= '0;
            head_started_reg    <= 1'b0;
            head_start_time_reg <= '0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                busy_reg <= 1'b1;
            end
            else if (execute)
            begin
                busy_reg <= 1'b0;
            end

            if (execute)
            begin
                out_valid_reg       <= 1'b1;
                time_now_reg        <= time_now_next;
                head_started_reg    <= head_started_next;
                head_start_time_reg <= head_start_time_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg    <= cmd.operation;
            id_reg    <= cmd.job_id;
            burst_reg <= cmd.burst_length;
        end
        if (execute)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.segment_valid    = result_reg.segment_valid;
    assign result.segment_job      = result_reg.segment_job;
    assign result.segment_begin    = result_reg.segment_begin;
    assign result.segment_end      = result_reg.segment_end;
    assign result.job_done         = result_reg.job_done;
    assign result.turnaround       = result_reg.turnaround;
    assign result.waiting          = result_reg.waiting;
    assign result.running_valid    = result_reg.running_valid;
    assign result.running_job      = result_reg.running_job;
    assign result.arrival_rejected = result_reg.arrival_rejected;

    `ASSERT_CLK(a_exec_gives_result, clk, rst_n, execute |=> out_valid_reg)
    `ASSERT_NEVER(a_queue_no_gap, clk, rst_n, ((valid_vec + ONE_VEC) & valid_vec) != '0)
    `ASSERT_NEVER(a_started_needs_head, clk, rst_n, head_started_reg && !cell_entry[0].valid)
    `ASSERT_NEVER(a_done_has_segment, clk, rst_n,
        out_valid_reg && result_reg.job_done && !result_reg.segment_valid)

endmodule

[verif/sjf_schedule_checker.sv]
// Checker for the scheduler: predicts each result item from the accepted input items and compares
`timescale 1ns / 100ps

module sjf_schedule_checker (
    input  logic   clk,
    input  logic   rst_n,
    sjf_cmd_if     cmd,
    sjf_result_if  result,
    output int     mismatches,
    output int     pending
);

    typedef struct packed {
        logic               segment_valid;
        sjf_pkg::id_t       segment_job;
        sjf_pkg::out_time_t segment_begin;
        sjf_pkg::out_time_t segment_end;
        logic               job_done;
        sjf_pkg::out_time_t turnaround;
        sjf_pkg::out_time_t waiting;
        logic               running_valid;
        sjf_pkg::id_t       running_job;
        logic               arrival_rejected;
    } sched_result_t;

    logic            job_live    [sjf_pkg::NUM_JOBS];
    sjf_pkg::burst_t job_burst   [sjf_pkg::NUM_JOBS];
    sjf_pkg::burst_t job_served  [sjf_pkg::NUM_JOBS];
    sjf_pkg::time_t  job_arrival [sjf_pkg::NUM_JOBS];
    sjf_pkg::id_t    run_order   [sjf_pkg::NUM_JOBS];
    sjf_pkg::time_t  sched_now;
    logic            head_running;
    sjf_pkg::time_t  head_since;

    sched_result_t expected_results[$];

    function automatic sched_result_t schedule_step(input logic op, input sjf_pkg::id_t id,
                                                    input sjf_pkg::burst_t burst);
        sched_result_t   r;
        int              n;
        int              pos;
        int              i;
        sjf_pkg::id_t    head;
        sjf_pkg::time_t  turn;
        r = '0;
        n = 0;
        for (i = 0; i < sjf_pkg::NUM_JOBS; i++)
        begin
            if (job_live[i])
                n++;
        end
        if (op == sjf_pkg::OP_ARRIVAL)
        begin
            if (job_live[id] || burst == '0 || n >= sjf_pkg::NUM_JOBS)
                r.arrival_rejected = 1'b1;
            else
            begin
                pos = 0;
                while (pos < n && job_burst[run_order[pos]] < burst)
                    pos++;
                // new head pushes the old one out; only a head that ran has a segment
                if (pos == 0 && n > 0)
                begin
                    if (head_running)
                    begin
                        r.segment_valid = 1'b1;
                        r.segment_job   = run_order[0];
                        r.segment_begin = head_since;
                        r.segment_end   = sched_now;
                    end
                    head_running = 1'b0;
                end
                for (i = n; i > pos; i--)
                    run_order[i] = run_order[i-1];
                run_order[pos]  = id;
                job_live[id]    = 1'b1;
                job_burst[id]   = burst;
                job_served[id]  = '0;
                job_arrival[id] = sched_now;
                n++;
            end
        end
        else if (n == 0)
            sched_now = sched_now + 1'b1;
        else
        begin
            head = run_order[0];
            if (!head_running)
            begin
                head_running = 1'b1;
                head_since   = sched_now;
            end
            job_served[head] = job_served[head] + 1'b1;
            sched_now = sched_now + 1'b1;
            if (job_served[head] >= job_burst[head])
            begin
                turn = sched_now - job_arrival[head];
                r.segment_valid = 1'b1;
                r.segment_job   = head;
                r.segment_begin = head_since;
                r.segment_end   = sched_now;
                r.job_done      = 1'b1;
                r.turnaround    = turn;
                r.waiting       = turn - sjf_pkg::time_t'(job_burst[head]);
                job_live[head]  = 1'b0;
                for (i = 0; i + 1 < n; i++)
                    run_order[i] = run_order[i+1];
                n--;
                head_running = 1'b0;
            end
        end
        if (n > 0)
        begin
            r.running_valid = 1'b1;
            r.running_job   = run_order[0];
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            job_live     = '{default: 1'b0};
            sched_now    = '0;
            head_running = 1'b0;
            head_since   = '0;
            mismatches   = 0;
            expected_results.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result item with none expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("segment_valid", 16'(want.segment_valid),
                                  16'(result.segment_valid));
                    compare_field("segment_job", 16'(want.segment_job),
                                  16'(result.segment_job));
                    compare_field("segment_begin", want.segment_begin, result.segment_begin);
                    compare_field("segment_end", want.segment_end, result.segment_end);
                    compare_field("job_done", 16'(want.job_done), 16'(result.job_done));
                    compare_field("turnaround", want.turnaround, result.turnaround);
                    compare_field("waiting", want.waiting, result.waiting);
                    compare_field("running_valid", 16'(want.running_valid),
                                  16'(result.running_valid));
                    compare_field("running_job", 16'(want.running_job),
                                  16'(result.running_job));
                    compare_field("arrival_rejected", 16'(want.arrival_rejected),
                                  16'(result.arrival_rejected));
                end
            end
            if (cmd.valid && cmd.ready)
                expected_results.push_back(schedule_step(cmd.operation, cmd.job_id,
                                                         cmd.burst_length));
        end
        pending = expected_results.size();
    end

endmodule

[verif/tb_top.sv]
// Testbench top: clock, reset, arrival and tick stimulus, result receiver and verdict
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_ITEMS   = 1230;
    localparam int RECEIVER_HOLD  = 120;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   quiet_cycles = 0;
    logic steady = 1'b0;
    logic stall_req = 1'b0;

    sjf_cmd_if    cmd();
    sjf_result_if result();

    preemptive_sjf_scheduler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .result (result)
    );

    sjf_schedule_checker sched_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[preemptive_sjf_scheduler] ERROR");
        $finish;
    end

    initial
    begin
        logic stall_taken;
        stall_taken  = 1'b0;
        result.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_req && !stall_taken)
            begin
                stall_taken = 1'b1;
                result.ready <= 1'b0;
                repeat (RECEIVER_HOLD) @(posedge clk);
            end
            result.ready <= steady || ($urandom_range(99) >= 16);
        end
    end

    task automatic offer(input logic op, input sjf_pkg::id_t id, input sjf_pkg::burst_t burst);
        while (!steady && $urandom_range(99) < 16)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid        <= 1'b1;
        cmd.operation    <= op;
        cmd.job_id       <= id;
        cmd.burst_length <= burst;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    task automatic offer_tick();
        offer(sjf_pkg::OP_TICK, sjf_pkg::id_t'($urandom_range(sjf_pkg::NUM_JOBS - 1)),
              sjf_pkg::burst_t'($urandom_range(1023)));
    endtask

    initial
    begin
        int              n;
        int              tick_pct;
        int              roll;
        sjf_pkg::burst_t burst;

        rst_n            = 1'b0;
        cmd.valid        = 1'b0;
        cmd.operation    = sjf_pkg::OP_ARRIVAL;
        cmd.job_id       = '0;
        cmd.burst_length = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(sjf_pkg::OP_ARRIVAL, 3'd0, 10'd4);
        offer(sjf_pkg::OP_ARRIVAL, 3'd0, 10'd9);
        offer(sjf_pkg::OP_ARRIVAL, 3'd1, 10'd0);
        offer(sjf_pkg::OP_ARRIVAL, 3'd1, 10'd1023);
        offer(sjf_pkg::OP_ARRIVAL, 3'd7, 10'd4);
        offer_tick();
        offer(sjf_pkg::OP_ARRIVAL, 3'd2, 10'd1);
        // short job preempts, then the queue drains in burst order up to the long job
        repeat (8) offer_tick();
        offer(sjf_pkg::OP_ARRIVAL, 3'd6, 10'd2);
        offer(sjf_pkg::OP_ARRIVAL, 3'd5, 10'd3);
        offer(sjf_pkg::OP_ARRIVAL, 3'd4, 10'd5);
        offer(sjf_pkg::OP_ARRIVAL, 3'd3, 10'd7);
        offer(sjf_pkg::OP_ARRIVAL, 3'd2, 10'd6);
        offer(sjf_pkg::OP_ARRIVAL, 3'd0, 10'd1);
        offer(sjf_pkg::OP_ARRIVAL, 3'd7, 10'd8);
        offer(sjf_pkg::OP_ARRIVAL, 3'd3, 10'd2);

        tick_pct = 85;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(2))
                    0: tick_pct = 30;
                    1: tick_pct = 60;
                    default: tick_pct = 88;
                endcase
            end
            steady = (n >= 800 && n < 1000);
            if (n == 300)
                stall_req = 1'b1;
            if (n == 600)
            begin
                cmd.valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
            end
            if ($urandom_range(99) < tick_pct)
                offer_tick();
            else
            begin
                roll = $urandom_range(99);
                if (roll < 2)
                    burst = '0;
                else if (roll < 4)
                    burst = sjf_pkg::burst_t'($urandom_range(1023, 64));
                else
                    burst = sjf_pkg::burst_t'($urandom_range(6, 1));
                offer(sjf_pkg::OP_ARRIVAL,
                      sjf_pkg::id_t'($urandom_range(sjf_pkg::NUM_JOBS - 1)), burst);
            end
        end

        cmd.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[preemptive_sjf_scheduler] OK");
        else
            $display("[preemptive_sjf_scheduler] ERROR");
        $finish;
    end

endmodule
